[hdl/cct_pkg.sv]
// Package for the chain code boundary tracer: sizes, payload types, codes and direction tables.
package cct_pkg;

  // Image store geometry and label width.
  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int LABEL_BITS = 8;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_BITS  = $clog2(DEPTH);

  // Rows and columns in use never exceed the store or the 8-bit coordinate range.
  localparam int ROW_LIMIT = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int COL_LIMIT = (MAX_COLS < 256) ? MAX_COLS : 256;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [8:0] COUNT_RESET = 9'd256;

  localparam logic [2:0] SEARCH_RESET = 3'd4;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_STEP     = 3'd1,
    KIND_ABSENT   = 3'd2,
    KIND_ISOLATED = 3'd3,
    KIND_NO_TRACE = 3'd4
  } kind_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] label;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic [2:0] direction;
    logic       last;
  } result_t;

  // Image size in use, after clamping.
  typedef struct packed {
    logic [8:0] rows_used;
    logic [8:0] cols_used;
  } geom_t;

  // One beat of requests towards the image store.
  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [LABEL_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  raddr;
  } ram_req_t;

  // Linear address of a pixel in the store.
  function automatic logic [ADDR_BITS-1:0] pixel_addr(logic [7:0] r, logic [7:0] c);
    return ADDR_BITS'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // Row offset of a chain direction; rows grow downwards.
  function automatic logic signed [1:0] step_dr(logic [2:0] dir);
    logic signed [1:0] d;
    case (dir)
      3'd1, 3'd2, 3'd3: d = 2'b11;
      3'd5, 3'd6, 3'd7: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // Column offset of a chain direction.
  function automatic logic signed [1:0] step_dc(logic [2:0] dir);
    logic signed [1:0] d;
    case (dir)
      3'd0, 3'd1, 3'd7: d = 2'b01;
      3'd3, 3'd4, 3'd5: d = 2'b11;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // Search direction to resume from, indexed by the direction before the one taken.
  function automatic logic [2:0] next_search(logic [2:0] dir);
    logic [2:0] s;
    case (dir)
      3'd0:    s = 3'd6;
      3'd1:    s = 3'd0;
      3'd2:    s = 3'd0;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd2;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd4;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

endpackage

[hdl/cct_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module cct_ram #(
  parameter int DEPTH     = 65536,
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/cct_ctrl.sv]
// Sequencer of the tracer: pixel writes, raster scan for a start point and neighbour probing.
module cct_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  cct_pkg::cmd_t                     cmd_i,
  input  cct_pkg::geom_t                    geom_i,
  input  logic [cct_pkg::LABEL_BITS-1:0]    rd_data_i,
  output cct_pkg::ram_req_t                 ram_req_o,
  output logic                              busy_o,
  output logic                              res_valid_o,
  output cct_pkg::result_t                  res_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_PROBE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Trace state.
  logic [7:0] start_row_q, start_row_d, start_col_q, start_col_d;
  logic [7:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [2:0] search_q, search_d;
  logic [cct_pkg::LABEL_BITS-1:0] label_q, label_d;
  logic tracing_q, tracing_d;

  // Read issue stage.
  logic [7:0] iss_row_q, iss_row_d, iss_col_q, iss_col_d;
  logic [2:0] iss_k_q, iss_k_d;
  logic       iss_done_q, iss_done_d;

  // Compare stage, lined up with the read data.
  logic       chk_valid_q, chk_valid_d, chk_ok_q, chk_ok_d;
  logic [7:0] chk_row_q, chk_row_d, chk_col_q, chk_col_d;
  logic [2:0] chk_dir_q, chk_dir_d;

  // Result register.
  logic             res_valid_q, res_valid_d;
  cct_pkg::result_t res_q, res_d;

  logic [cct_pkg::LABEL_BITS-1:0] lbl_in;
  logic                           wr_in_bounds, start_ok;
  logic                           col_last, row_last;
  logic [2:0]                     probe_dir;
  logic signed [9:0]              nb_row, nb_col;
  logic                           nb_ok;
  logic                           hit, back_home;
  logic [2:0]                     prev_dir;

  assign lbl_in       = cct_pkg::LABEL_BITS'(cmd_i.label);
  assign wr_in_bounds = (int'(cmd_i.row) < cct_pkg::MAX_ROWS) &&
                        (int'(cmd_i.col) < cct_pkg::MAX_COLS);
  assign start_ok     = (lbl_in != '0) && (geom_i.rows_used != 9'd0) &&
                        (geom_i.cols_used != 9'd0);

  // Raster position bookkeeping.
  assign col_last = ({1'b0, iss_col_q} == (geom_i.cols_used - 9'd1));
  assign row_last = ({1'b0, iss_row_q} == (geom_i.rows_used - 9'd1));

  // Neighbour under probe and whether it lies inside the image in use.
  assign probe_dir = search_q + iss_k_q;
  assign nb_row    = $signed({2'b00, cur_row_q}) + 10'(cct_pkg::step_dr(probe_dir));
  assign nb_col    = $signed({2'b00, cur_col_q}) + 10'(cct_pkg::step_dc(probe_dir));
  assign nb_ok     = !nb_row[9] && !nb_col[9] &&
                     (nb_row[8:0] < geom_i.rows_used) && (nb_col[8:0] < geom_i.cols_used);

  // A pixel read last cycle holds the label being traced.
  assign hit       = chk_valid_q && chk_ok_q && (rd_data_i == label_q);
  assign back_home = (chk_row_q == start_row_q) && (chk_col_q == start_col_q);
  assign prev_dir  = chk_dir_q - 3'd1;

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    start_row_d = start_row_q;
    start_col_d = start_col_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    search_d    = search_q;
    label_d     = label_q;
    tracing_d   = tracing_q;
    iss_row_d   = iss_row_q;
    iss_col_d   = iss_col_q;
    iss_k_d     = iss_k_q;
    iss_done_d  = iss_done_q;
    chk_valid_d = 1'b0;
    chk_ok_d    = chk_ok_q;
    chk_row_d   = chk_row_q;
    chk_col_d   = chk_col_q;
    chk_dir_d   = chk_dir_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = cct_pkg::pixel_addr(cmd_i.row, cmd_i.col);
    ram_req_o.wdata = lbl_in;
    ram_req_o.raddr = (state_q == ST_SCAN) ? cct_pkg::pixel_addr(iss_row_q, iss_col_q)
                                           : cct_pkg::pixel_addr(nb_row[7:0], nb_col[7:0]);

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i.func)
            cct_pkg::FUNC_WRITE: begin
              ram_req_o.we = wr_in_bounds;
            end
            cct_pkg::FUNC_START: begin
              tracing_d = 1'b0;
              if (start_ok) begin
                state_d    = ST_SCAN;
                label_d    = lbl_in;
                iss_row_d  = 8'd0;
                iss_col_d  = 8'd0;
                iss_done_d = 1'b0;
              end else begin
                res_valid_d = 1'b1;
                res_d       = '{kind: cct_pkg::KIND_ABSENT, out_row: 8'd0, out_col: 8'd0,
                                direction: 3'd0, last: 1'b0};
              end
            end
            cct_pkg::FUNC_ADVANCE: begin
              if (tracing_q) begin
                state_d    = ST_PROBE;
                iss_k_d    = 3'd0;
                iss_done_d = 1'b0;
              end else begin
                res_valid_d = 1'b1;
                res_d       = '{kind: cct_pkg::KIND_NO_TRACE, out_row: 8'd0, out_col: 8'd0,
                                direction: 3'd0, last: 1'b0};
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one raster read a cycle.
        if (!iss_done_q) begin
          chk_valid_d = 1'b1;
          chk_ok_d    = 1'b1;
          chk_row_d   = iss_row_q;
          chk_col_d   = iss_col_q;
          if (col_last) begin
            iss_col_d = 8'd0;
            if (row_last) begin
              iss_done_d = 1'b1;
            end else begin
              iss_row_d = iss_row_q + 8'd1;
            end
          end else begin
            iss_col_d = iss_col_q + 8'd1;
          end
        end
        // Compare the pixel read in the previous cycle.
        if (hit) begin
          state_d     = ST_IDLE;
          start_row_d = chk_row_q;
          start_col_d = chk_col_q;
          cur_row_d   = chk_row_q;
          cur_col_d   = chk_col_q;
          search_d    = cct_pkg::SEARCH_RESET;
          tracing_d   = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{kind: cct_pkg::KIND_START, out_row: chk_row_q, out_col: chk_col_q,
                          direction: 3'd0, last: 1'b0};
        end else if (iss_done_q && !chk_valid_q) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_d       = '{kind: cct_pkg::KIND_ABSENT, out_row: 8'd0, out_col: 8'd0,
                          direction: 3'd0, last: 1'b0};
        end
      end

      ST_PROBE: begin
        // Issue one neighbour read a cycle, counter-clockwise.
        if (!iss_done_q) begin
          chk_valid_d = 1'b1;
          chk_ok_d    = nb_ok;
          chk_row_d   = nb_row[7:0];
          chk_col_d   = nb_col[7:0];
          chk_dir_d   = probe_dir;
          if (iss_k_q == 3'd7) begin
            iss_done_d = 1'b1;
          end else begin
            iss_k_d = iss_k_q + 3'd1;
          end
        end
        // First matching neighbour becomes the new current point.
        if (hit) begin
          state_d     = ST_IDLE;
          cur_row_d   = chk_row_q;
          cur_col_d   = chk_col_q;
          search_d    = cct_pkg::next_search(prev_dir);
          tracing_d   = !back_home;
          res_valid_d = 1'b1;
          res_d       = '{kind: cct_pkg::KIND_STEP, out_row: chk_row_q, out_col: chk_col_q,
                          direction: chk_dir_q, last: back_home};
        end else if (iss_done_q && !chk_valid_q) begin
          state_d     = ST_IDLE;
          tracing_d   = 1'b0;
          res_valid_d = 1'b1;
          res_d       = '{kind: cct_pkg::KIND_ISOLATED, out_row: cur_row_q, out_col: cur_col_q,
                          direction: 3'd0, last: 1'b1};
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_row_q <= 8'd0;
      start_col_q <= 8'd0;
      cur_row_q   <= 8'd0;
      cur_col_q   <= 8'd0;
      search_q    <= cct_pkg::SEARCH_RESET;
      label_q     <= '0;
      tracing_q   <= 1'b0;
      iss_done_q  <= 1'b0;
      chk_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_row_q <= start_row_d;
      start_col_q <= start_col_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      search_q    <= search_d;
      label_q     <= label_d;
      tracing_q   <= tracing_d;
      iss_done_q  <= iss_done_d;
      chk_valid_q <= chk_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    iss_row_q <= iss_row_d;
    iss_col_q <= iss_col_d;
    iss_k_q   <= iss_k_d;
    chk_ok_q  <= chk_ok_d;
    chk_row_q <= chk_row_d;
    chk_col_q <= chk_col_d;
    chk_dir_q <= chk_dir_d;
    res_q     <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A result is only shown once the sequencer is back at rest.
  a_res_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> state_q == ST_IDLE)
    else $error("result strobe while the sequencer is busy");

  // A result flagged as last always closes the trace.
  a_last_ends_trace : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> !tracing_q)
    else $error("trace still active after a last step");

  // A reported start point is both the start and the current point of a live trace.
  a_start_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.kind == cct_pkg::KIND_START |->
      tracing_q && cur_row_q == start_row_q && cur_col_q == start_col_q)
    else $error("start point reported without a matching trace state");

  // Probing only happens within a trace.
  a_probe_traces : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> tracing_q)
    else $error("neighbour probe without an active trace");

endmodule

[hdl/chain_code_boundary_tracer_top.sv]
// Top level of the chain code boundary tracer: configuration registers, image store and sequencer.
//
// A command is taken when start_i is high and busy_o is low. A pixel write takes
// effect at that edge, gives no result and leaves busy_o low. A start scans the image
// in use in raster order with one store read per cycle and stays busy until the
// label is first found or every pixel in use has been read; a label of zero or an
// empty image is answered at once. An advance probes the eight neighbours with one
// store read per cycle and stays busy until a neighbour matches or all eight have
// been read; with no trace in progress it is answered at once. Each result is
// shown on res_o for exactly one cycle, marked by res_valid_o, in the cycle after its
// command finishes, and the receiver cannot hold it off. The image store is not
// cleared after reset: every pixel inside the image in use must be written before a
// start or an advance reads it. Configuration writes are always ready and must only be
// issued while no command is in progress.
module chain_code_boundary_tracer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  cct_pkg::cmd_t                      cmd_i,
  output logic                               res_valid_o,
  output cct_pkg::result_t                   res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cct_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [8:0]                         cfg_data_i
);

  logic [8:0] row_count_q, row_count_d, col_count_q, col_count_d;
  cct_pkg::geom_t                 geom;
  cct_pkg::ram_req_t              ram_req;
  logic [cct_pkg::LABEL_BITS-1:0] rd_data;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cct_pkg::CFG_ROW_COUNT: row_count_d = cfg_data_i;
        cct_pkg::CFG_COL_COUNT: col_count_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= cct_pkg::COUNT_RESET;
      col_count_q <= cct_pkg::COUNT_RESET;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  // Clamp the image size in use to the store.
  assign geom.rows_used = (row_count_q > 9'(cct_pkg::ROW_LIMIT)) ? 9'(cct_pkg::ROW_LIMIT)
                                                                : row_count_q;
  assign geom.cols_used = (col_count_q > 9'(cct_pkg::COL_LIMIT)) ? 9'(cct_pkg::COL_LIMIT)
                                                                : col_count_q;

  // Labelled image store.
  cct_ram #(
    .DEPTH     (cct_pkg::DEPTH),
    .ADDR_BITS (cct_pkg::ADDR_BITS),
    .DATA_BITS (cct_pkg::LABEL_BITS)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_data)
  );

  // Command sequencer.
  cct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .geom_i      (geom),
    .rd_data_i   (rd_data),
    .ram_req_o   (ram_req),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
